// File: sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// shared constants, codes and controller/datapath handshake types
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

    // parameter defaults
    localparam int STORE_DEPTH_DEF     = 256;
    localparam int MAX_ARRAY_ELEMS_DEF = 15;
    localparam int CHUNK_BYTES_DEF     = 8;

    // framing bytes
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    localparam int MIN_FRAME_BYTES = 3;
    localparam int HDR_BYTES       = 3;
    localparam int LEN_OVERHEAD    = 2;
    localparam int FLOAT_BYTES     = 4;
    localparam int MAX_CHUNKS      = 32;

    // position arithmetic width, holds start + length + 1
    localparam int POS_W = 10;

    // reciprocal constants for the small constant divisions
    localparam logic [9:0] RECIP3     = 10'd683;
    localparam int         RECIP3_SH  = 11;
    localparam logic [7:0] RECIP17    = 8'd241;
    localparam int         RECIP17_SH = 12;
    localparam logic [9:0] RECIP33    = 10'd993;
    localparam int         RECIP33_SH = 15;

    // config register indexes
    localparam int         CFG_IDX_W      = 1;
    localparam logic [0:0] CFG_SKIP_ZEROS = 1'b0;
    localparam logic [0:0] CFG_SKIP_COUNT = 1'b1;

    // output tdata layout
    localparam int OUT_DATA_W = 152;
    localparam int ID_LSB     = 0;
    localparam int IDX_LSB    = 8;
    localparam int INT_LSB    = 13;
    localparam int FLT_LSB    = 45;
    localparam int TXT_LSB    = 77;
    localparam int TC_LSB     = 141;
    localparam int ERR_LSB    = 145;
    localparam int FIELDS_W   = 148;

    typedef enum logic [2:0] {
        KIND_INT   = 3'd0,
        KIND_FLOAT = 3'd1,
        KIND_TEXT  = 3'd2,
        KIND_IARR  = 3'd3,
        KIND_FARR  = 3'd4,
        KIND_PAIR  = 3'd5,
        KIND_ERR   = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_CSUM  = 3'd1,
        ERR_FSIZE = 3'd2,
        ERR_TYPE  = 3'd3,
        ERR_SHORT = 3'd4
    } err_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_SCAN_INIT,
        OP_SCAN_STEP,
        OP_HDR_SCAN,
        OP_HDR_FIX,
        OP_ID,
        OP_TYPE,
        OP_LEN,
        OP_INIT,
        OP_DIV_STEP,
        OP_SETUP,
        OP_GI_STEP,
        OP_GI_END,
        OP_GF_STEP,
        OP_LOAD_RES,
        OP_LOAD_ERR,
        OP_NEXT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        err_t   err;
        logic   err_id_zero;
        logic   in_ready;
    } dp_cmd_t;

    typedef struct packed {
        logic  close;
        logic  fovf;
        logic  scan_end;
        logic  rd_zero;
        logic  hdr_short;
        logic  len_bad;
        logic  csum_bad;
        kind_t kind;
        logic  dl_lt4;
        logic  text_big;
        logic  cnt_big;
        logic  div_last;
        logic  step_bad;
        logic  ib_zero;
        logic  fb_zero;
        logic  out_taken;
        logic  res_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/sfd_ram.sv
// ----------------------------------------------------------------------------
// sfd_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire  [$clog2(DEPTH)-1:0]  waddr,
    input  wire  [WIDTH-1:0]          wdata,
    input  wire  [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/sfd_datapath.sv
// ----------------------------------------------------------------------------
// sfd_datapath
// byte intake, frame store, header and element gathering, result register
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_datapath #(
    parameter int STORE_DEPTH     = sfd_pkg::STORE_DEPTH_DEF,
    parameter int MAX_ARRAY_ELEMS = sfd_pkg::MAX_ARRAY_ELEMS_DEF,
    parameter int CHUNK_BYTES     = sfd_pkg::CHUNK_BYTES_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               s_tvalid,
    input  wire  [7:0]        s_tdata,
    input  wire  [7:0]        skip_count,
    input  sfd_pkg::dp_cmd_t  cmd,
    output sfd_pkg::dp_stat_t stat,
    input  wire               m_tready,
    output logic              out_valid,
    output logic [7:0]        out_id,
    output logic [2:0]        out_kind,
    output logic [4:0]        out_idx,
    output logic [31:0]       out_int,
    output logic [31:0]       out_flt,
    output logic [63:0]       out_txt,
    output logic [3:0]        out_tc,
    output logic [2:0]        out_err,
    output logic              out_last
);
    import sfd_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    function automatic logic [2:0] min4(input logic [7:0] v);
        min4 = (v >= 8'(FLOAT_BYTES)) ? 3'(FLOAT_BYTES) : v[2:0];
    endfunction

    // intake state
    logic [CW-1:0]    wcnt_reg, wcnt_next;
    logic             cr_reg, cr_next;
    logic             ovf_reg, ovf_next;
    logic [CW-1:0]    n_reg, n_next;
    logic             fovf_reg, fovf_next;
    // decode state
    logic [POS_W-1:0] addr_reg, addr_next;
    logic [POS_W-1:0] p_reg, p_next;
    logic [POS_W-1:0] fst_reg, fst_next;
    logic [7:0]       id_reg, id_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       len_reg, len_next;
    logic [9:0]       sum_reg, sum_next;
    kind_t            kind_reg, kind_next;
    logic [4:0]       idx_reg, idx_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [7:0]       rem_reg, rem_next;
    logic [3:0]       c_reg, c_next;
    logic [7:0]       divq_reg, divq_next;
    logic [4:0]       divr_reg, divr_next;
    logic [2:0]       dcnt_reg, dcnt_next;
    logic [2:0]       ib_reg, ib_next;
    logic [3:0]       fb_reg, fb_next;
    logic [2:0]       lane_reg, lane_next;
    logic [31:0]      iacc_reg, iacc_next;
    logic [63:0]      facc_reg, facc_next;
    // result register
    logic             ov_reg, ov_next;
    logic [7:0]       oid_reg, oid_next;
    logic [2:0]       okind_reg, okind_next;
    logic [4:0]       oidx_reg, oidx_next;
    logic [31:0]      oint_reg, oint_next;
    logic [31:0]      oflt_reg, oflt_next;
    logic [63:0]      otxt_reg, otxt_next;
    logic [3:0]       otc_reg, otc_next;
    logic [2:0]       oerr_reg, oerr_next;
    logic             olast_reg, olast_next;

    logic             accept, arm, store, close;
    logic [7:0]       rdata;
    logic [7:0]       dl;
    logic [POS_W-1:0] n_pos;
    logic [19:0]      prod3;
    logic [15:0]      prod17;
    logic [17:0]      prod33;
    logic [7:0]       q3;
    logic [3:0]       q17;
    logic [2:0]       q33;
    logic             m17, m33;
    kind_t            cls_kind;
    logic [3:0]       arr_cnt;
    logic [5:0]       dtmp;
    logic [7:0]       step;
    logic [3:0]       chunk;
    logic             res_last;

    assign accept = cmd.in_ready & s_tvalid;
    assign arm    = !cr_reg && (s_tdata == BYTE_CR) && (wcnt_reg >= CW'(MIN_FRAME_BYTES));
    assign store  = accept && !arm && !cr_reg && (wcnt_reg < CW'(STORE_DEPTH));
    assign close  = accept && cr_reg && (s_tdata == BYTE_LF);

    sfd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store),
        .waddr (wcnt_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (addr_next[AW-1:0]),
        .rdata (rdata)
    );

    assign dl     = len_reg - 8'(LEN_OVERHEAD);
    assign n_pos  = POS_W'(n_reg);
    assign step   = divq_reg;
    assign prod3  = sum_reg * RECIP3;
    assign q3     = 8'(prod3 >> RECIP3_SH);
    assign prod17 = type_reg * RECIP17;
    assign q17    = 4'(prod17 >> RECIP17_SH);
    assign prod33 = type_reg * RECIP33;
    assign q33    = 3'(prod33 >> RECIP33_SH);
    assign m17    = ({q17, 4'b0000} + {4'b0000, q17}) == type_reg;
    assign m33    = ({q33, 5'b00000} + {5'b00000, q33}) == type_reg;
    assign dtmp   = {divr_reg, divq_reg[7]};
    assign chunk  = (rem_reg >= 8'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : rem_reg[3:0];

    // type byte classification
    always_comb
    begin
        cls_kind = KIND_ERR;
        arr_cnt  = 4'd0;
        if (type_reg == 8'd0)
        begin
            cls_kind = KIND_INT;
        end
        else if (type_reg == 8'd1)
        begin
            cls_kind = KIND_FLOAT;
        end
        else if (type_reg == 8'd2)
        begin
            cls_kind = KIND_TEXT;
        end
        else if (type_reg[3:0] == 4'd0)
        begin
            cls_kind = KIND_IARR;
            arr_cnt  = type_reg[7:4];
        end
        else if (m17)
        begin
            cls_kind = KIND_FARR;
            arr_cnt  = q17;
        end
        else if (m33)
        begin
            cls_kind = KIND_PAIR;
            arr_cnt  = {1'b0, q33};
        end
    end

    always_comb
    begin
        case (kind_reg)
            KIND_TEXT: res_last = (rem_reg == {4'd0, c_reg});
            KIND_IARR,
            KIND_FARR,
            KIND_PAIR: res_last = (idx_reg == 5'({1'b0, cnt_reg} - 5'd1));
            default:   res_last = 1'b1;
        endcase
    end

    always_comb
    begin
        stat.close     = close;
        stat.fovf      = fovf_reg;
        stat.scan_end  = addr_reg >= n_pos;
        stat.rd_zero   = rdata == 8'd0;
        stat.hdr_short = (p_reg + POS_W'(HDR_BYTES)) > n_pos;
        stat.len_bad   = (len_reg < 8'(LEN_OVERHEAD))
                      || ((p_reg + {2'b00, len_reg} + POS_W'(1)) >= n_pos);
        stat.csum_bad  = rdata != q3;
        stat.kind      = cls_kind;
        stat.dl_lt4    = dl < 8'(FLOAT_BYTES);
        stat.text_big  = {2'b00, dl} > 10'(MAX_CHUNKS * CHUNK_BYTES);
        stat.cnt_big   = {1'b0, arr_cnt} > 5'(MAX_ARRAY_ELEMS);
        stat.div_last  = dcnt_reg == 3'd7;
        case (kind_reg)
            KIND_FARR: stat.step_bad = step != 8'(FLOAT_BYTES);
            KIND_PAIR: stat.step_bad = step < 8'(FLOAT_BYTES);
            default:   stat.step_bad = 1'b0;
        endcase
        stat.ib_zero   = ib_reg == 3'd0;
        stat.fb_zero   = fb_reg == 4'd0;
        stat.out_taken = ov_reg & m_tready;
        stat.res_last  = olast_reg;
    end

    always_comb
    begin
        wcnt_next  = wcnt_reg;
        cr_next    = cr_reg;
        ovf_next   = ovf_reg;
        n_next     = n_reg;
        fovf_next  = fovf_reg;
        addr_next  = addr_reg;
        p_next     = p_reg;
        fst_next   = fst_reg;
        id_next    = id_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        kind_next  = kind_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        c_next     = c_reg;
        divq_next  = divq_reg;
        divr_next  = divr_reg;
        dcnt_next  = dcnt_reg;
        ib_next    = ib_reg;
        fb_next    = fb_reg;
        lane_next  = lane_reg;
        iacc_next  = iacc_reg;
        facc_next  = facc_reg;
        ov_next    = ov_reg & ~m_tready;
        oid_next   = oid_reg;
        okind_next = okind_reg;
        oidx_next  = oidx_reg;
        oint_next  = oint_reg;
        oflt_next  = oflt_reg;
        otxt_next  = otxt_reg;
        otc_next   = otc_reg;
        oerr_next  = oerr_reg;
        olast_next = olast_reg;

        // byte intake
        if (accept)
        begin
            if (arm)
            begin
                cr_next = 1'b1;
            end
            else if (cr_reg)
            begin
                cr_next   = 1'b0;
                wcnt_next = '0;
                ovf_next  = 1'b0;
                if (close)
                begin
                    n_next    = wcnt_reg;
                    fovf_next = ovf_reg;
                end
            end
            else if (store)
            begin
                wcnt_next = wcnt_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        case (cmd.op)
            OP_SCAN_INIT:
            begin
                addr_next = '0;
            end
            OP_SCAN_STEP:
            begin
                addr_next = addr_reg + POS_W'(1);
            end
            OP_HDR_SCAN:
            begin
                p_next = addr_reg;
            end
            OP_HDR_FIX:
            begin
                p_next    = {2'b00, skip_count};
                addr_next = {2'b00, skip_count};
            end
            OP_ID:
            begin
                id_next   = rdata;
                addr_next = p_reg + POS_W'(1);
            end
            OP_TYPE:
            begin
                type_next = rdata;
                addr_next = p_reg + POS_W'(2);
            end
            OP_LEN:
            begin
                len_next  = rdata;
                addr_next = p_reg + {2'b00, rdata} + POS_W'(1);
                sum_next  = {2'b00, id_reg} + {2'b00, type_reg} + {2'b00, rdata};
            end
            OP_INIT:
            begin
                kind_next = cls_kind;
                cnt_next  = arr_cnt;
                p_next    = p_reg + POS_W'(HDR_BYTES);
                idx_next  = '0;
                rem_next  = dl;
                divq_next = dl;
                divr_next = '0;
                dcnt_next = '0;
            end
            OP_DIV_STEP:
            begin
                // one restoring division step of dl / count
                if (dtmp >= {2'b00, cnt_reg})
                begin
                    divr_next = 5'(dtmp - {2'b00, cnt_reg});
                    divq_next = {divq_reg[6:0], 1'b1};
                end
                else
                begin
                    divr_next = dtmp[4:0];
                    divq_next = {divq_reg[6:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 3'd1;
            end
            OP_SETUP:
            begin
                iacc_next = '0;
                facc_next = '0;
                lane_next = '0;
                addr_next = p_reg;
                fst_next  = p_reg;
                ib_next   = '0;
                fb_next   = '0;
                case (kind_reg)
                    KIND_INT:
                    begin
                        ib_next = min4(dl);
                    end
                    KIND_FLOAT,
                    KIND_FARR:
                    begin
                        fb_next = 4'(FLOAT_BYTES);
                    end
                    KIND_TEXT:
                    begin
                        fb_next = chunk;
                        c_next  = chunk;
                    end
                    KIND_IARR:
                    begin
                        ib_next = min4(step);
                    end
                    KIND_PAIR:
                    begin
                        ib_next  = min4(step - 8'(FLOAT_BYTES));
                        fb_next  = 4'(FLOAT_BYTES);
                        fst_next = p_reg + {2'b00, step} - POS_W'(FLOAT_BYTES);
                    end
                    default:
                    begin
                        ib_next = '0;
                    end
                endcase
            end
            OP_GI_STEP:
            begin
                iacc_next = {iacc_reg[23:0], rdata};
                ib_next   = ib_reg - 3'd1;
                addr_next = addr_reg + POS_W'(1);
            end
            OP_GI_END:
            begin
                addr_next = fst_reg;
            end
            OP_GF_STEP:
            begin
                facc_next[{lane_reg, 3'b000} +: 8] = rdata;
                lane_next = lane_reg + 3'd1;
                fb_next   = fb_reg - 4'd1;
                addr_next = addr_reg + POS_W'(1);
            end
            OP_LOAD_RES:
            begin
                ov_next    = 1'b1;
                oid_next   = id_reg;
                okind_next = kind_reg;
                oidx_next  = idx_reg;
                oint_next  = iacc_reg;
                oflt_next  = (kind_reg == KIND_TEXT) ? 32'd0 : facc_reg[31:0];
                otxt_next  = (kind_reg == KIND_TEXT) ? facc_reg : 64'd0;
                otc_next   = (kind_reg == KIND_TEXT) ? c_reg : 4'd0;
                oerr_next  = ERR_NONE;
                olast_next = res_last;
            end
            OP_LOAD_ERR:
            begin
                ov_next    = 1'b1;
                oid_next   = cmd.err_id_zero ? 8'd0 : id_reg;
                okind_next = KIND_ERR;
                oidx_next  = '0;
                oint_next  = '0;
                oflt_next  = '0;
                otxt_next  = '0;
                otc_next   = '0;
                oerr_next  = cmd.err;
                olast_next = 1'b1;
            end
            OP_NEXT:
            begin
                idx_next = idx_reg + 5'd1;
                if (kind_reg == KIND_TEXT)
                begin
                    p_next   = p_reg + POS_W'(CHUNK_BYTES);
                    rem_next = rem_reg - {4'd0, c_reg};
                end
                else
                begin
                    p_next = p_reg + {2'b00, step};
                end
            end
            default:
            begin
                addr_next = addr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcnt_reg <= '0;
            cr_reg   <= 1'b0;
            ovf_reg  <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            wcnt_reg <= wcnt_next;
            cr_reg   <= cr_next;
            ovf_reg  <= ovf_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        fovf_reg  <= fovf_next;
        addr_reg  <= addr_next;
        p_reg     <= p_next;
        fst_reg   <= fst_next;
        id_reg    <= id_next;
        type_reg  <= type_next;
        len_reg   <= len_next;
        sum_reg   <= sum_next;
        kind_reg  <= kind_next;
        idx_reg   <= idx_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        c_reg     <= c_next;
        divq_reg  <= divq_next;
        divr_reg  <= divr_next;
        dcnt_reg  <= dcnt_next;
        ib_reg    <= ib_next;
        fb_reg    <= fb_next;
        lane_reg  <= lane_next;
        iacc_reg  <= iacc_next;
        facc_reg  <= facc_next;
        oid_reg   <= oid_next;
        okind_reg <= okind_next;
        oidx_reg  <= oidx_next;
        oint_reg  <= oint_next;
        oflt_reg  <= oflt_next;
        otxt_reg  <= otxt_next;
        otc_reg   <= otc_next;
        oerr_reg  <= oerr_next;
        olast_reg <= olast_next;
    end

    assign out_valid = ov_reg;
    assign out_id    = oid_reg;
    assign out_kind  = okind_reg;
    assign out_idx   = oidx_reg;
    assign out_int   = oint_reg;
    assign out_flt   = oflt_reg;
    assign out_txt   = otxt_reg;
    assign out_tc    = otc_reg;
    assign out_err   = oerr_reg;
    assign out_last  = olast_reg;

endmodule

`default_nettype wire

// File: sv/sfd_ctrl.sv
// ----------------------------------------------------------------------------
// sfd_ctrl
// decode sequencer, drives datapath operations from datapath status
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               skip_zeros,
    input  sfd_pkg::dp_stat_t stat,
    output sfd_pkg::dp_cmd_t  cmd
);
    import sfd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_HCHK,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_DISP,
        ST_DIV,
        ST_DCHK,
        ST_SETUP,
        ST_GI,
        ST_GF,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd.op          = OP_NONE;
        cmd.err         = ERR_NONE;
        cmd.err_id_zero = 1'b0;
        cmd.in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.close)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (stat.fovf)
                begin
                    cmd.op          = OP_LOAD_ERR;
                    cmd.err         = ERR_SHORT;
                    cmd.err_id_zero = 1'b1;
                    state_next      = ST_OUT;
                end
                else if (skip_zeros)
                begin
                    cmd.op     = OP_SCAN_INIT;
                    state_next = ST_SCAN;
                end
                else
                begin
                    cmd.op     = OP_HDR_FIX;
                    state_next = ST_HCHK;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_end)
                begin
                    cmd.op          = OP_LOAD_ERR;
                    cmd.err         = ERR_SHORT;
                    cmd.err_id_zero = 1'b1;
                    state_next      = ST_OUT;
                end
                else if (stat.rd_zero)
                begin
                    cmd.op = OP_SCAN_STEP;
                end
                else
                begin
                    cmd.op     = OP_HDR_SCAN;
                    state_next = ST_HCHK;
                end
            end
            ST_HCHK:
            begin
                if (stat.hdr_short)
                begin
                    cmd.op          = OP_LOAD_ERR;
                    cmd.err         = ERR_SHORT;
                    cmd.err_id_zero = 1'b1;
                    state_next      = ST_OUT;
                end
                else
                begin
                    cmd.op     = OP_ID;
                    state_next = ST_H1;
                end
            end
            ST_H1:
            begin
                cmd.op     = OP_TYPE;
                state_next = ST_H2;
            end
            ST_H2:
            begin
                cmd.op     = OP_LEN;
                state_next = ST_H3;
            end
            ST_H3:
            begin
                if (stat.len_bad)
                begin
                    cmd.op     = OP_LOAD_ERR;
                    cmd.err    = ERR_SHORT;
                    state_next = ST_OUT;
                end
                else if (stat.csum_bad)
                begin
                    cmd.op     = OP_LOAD_ERR;
                    cmd.err    = ERR_CSUM;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                case (stat.kind)
                    KIND_INT:
                    begin
                        cmd.op     = OP_INIT;
                        state_next = ST_SETUP;
                    end
                    KIND_FLOAT:
                    begin
                        if (stat.dl_lt4)
                        begin
                            cmd.op     = OP_LOAD_ERR;
                            cmd.err    = ERR_FSIZE;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            cmd.op     = OP_INIT;
                            state_next = ST_SETUP;
                        end
                    end
                    KIND_TEXT:
                    begin
                        if (stat.text_big)
                        begin
                            cmd.op     = OP_LOAD_ERR;
                            cmd.err    = ERR_SHORT;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            cmd.op     = OP_INIT;
                            state_next = ST_SETUP;
                        end
                    end
                    KIND_IARR,
                    KIND_FARR,
                    KIND_PAIR:
                    begin
                        if (stat.cnt_big)
                        begin
                            cmd.op     = OP_LOAD_ERR;
                            cmd.err    = ERR_SHORT;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            cmd.op     = OP_INIT;
                            state_next = ST_DIV;
                        end
                    end
                    default:
                    begin
                        cmd.op     = OP_LOAD_ERR;
                        cmd.err    = ERR_TYPE;
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_last)
                begin
                    state_next = ST_DCHK;
                end
            end
            ST_DCHK:
            begin
                if (stat.step_bad)
                begin
                    cmd.op     = OP_LOAD_ERR;
                    cmd.err    = ERR_FSIZE;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.op     = OP_SETUP;
                state_next = ST_GI;
            end
            ST_GI:
            begin
                if (stat.ib_zero)
                begin
                    cmd.op     = OP_GI_END;
                    state_next = ST_GF;
                end
                else
                begin
                    cmd.op = OP_GI_STEP;
                end
            end
            ST_GF:
            begin
                if (stat.fb_zero)
                begin
                    cmd.op     = OP_LOAD_RES;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.op = OP_GF_STEP;
                end
            end
            ST_OUT:
            begin
                if (stat.out_taken)
                begin
                    if (stat.res_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.op     = OP_NEXT;
                        state_next = ST_SETUP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/serial_frame_decoder.sv
// ----------------------------------------------------------------------------
// serial_frame_decoder
// stores received bytes, closes a frame on CR LF and decodes it into items
// ----------------------------------------------------------------------------
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: rx_byte
// m_*       out  m_tvalid/m_tready  m_tdata, m_tuser: item_kind, m_tlast: last
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// bytes are taken only while no frame decodes
// a closed frame is walked through the single read port of the frame store:
//   a start step, a zero scan over the leading bytes when enabled, the
//   header, checksum and type checks, the divider and step check for
//   arrays, then per result the int bytes, the float/text bytes and the
//   output, which waits while m_tready stalls
// reset is asynchronous active low; the frame store is not cleared
// a stalled m_tready holds the result and the decoder in place
//
`default_nettype none

module serial_frame_decoder #(
    parameter int STORE_DEPTH     = sfd_pkg::STORE_DEPTH_DEF,
    parameter int MAX_ARRAY_ELEMS = sfd_pkg::MAX_ARRAY_ELEMS_DEF,
    parameter int CHUNK_BYTES     = sfd_pkg::CHUNK_BYTES_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [7:0]                       s_tdata,   // rx_byte
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // frame_id, element_index, int_word, float_bits, text_bytes,
    // text_count, error_code, zero pad
    output logic [sfd_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [2:0]                       m_tuser,   // item_kind
    output logic                             m_tlast,   // last
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [sfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [7:0]                       cfg_data
);
    import sfd_pkg::*;

    // configuration registers
    logic       skz_reg, skz_next;
    logic [7:0] skc_reg, skc_next;

    dp_cmd_t    cmd;
    dp_stat_t   stat;

    logic        out_valid;
    logic [7:0]  out_id;
    logic [2:0]  out_kind;
    logic [4:0]  out_idx;
    logic [31:0] out_int;
    logic [31:0] out_flt;
    logic [63:0] out_txt;
    logic [3:0]  out_tc;
    logic [2:0]  out_err;
    logic        out_last;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        skz_next = skz_reg;
        skc_next = skc_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SKIP_ZEROS: skz_next = cfg_data[0];
                CFG_SKIP_COUNT: skc_next = cfg_data;
                default:        skz_next = skz_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skz_reg <= 1'b1;
            skc_reg <= 8'd0;
        end
        else
        begin
            skz_reg <= skz_next;
            skc_reg <= skc_next;
        end
    end

    // sequencer
    sfd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .skip_zeros (skz_reg),
        .stat       (stat),
        .cmd        (cmd)
    );

    // store, header registers, divider, gather and result register
    sfd_datapath #(
        .STORE_DEPTH     (STORE_DEPTH),
        .MAX_ARRAY_ELEMS (MAX_ARRAY_ELEMS),
        .CHUNK_BYTES     (CHUNK_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tdata    (s_tdata),
        .skip_count (skc_reg),
        .cmd        (cmd),
        .stat       (stat),
        .m_tready   (m_tready),
        .out_valid  (out_valid),
        .out_id     (out_id),
        .out_kind   (out_kind),
        .out_idx    (out_idx),
        .out_int    (out_int),
        .out_flt    (out_flt),
        .out_txt    (out_txt),
        .out_tc     (out_tc),
        .out_err    (out_err),
        .out_last   (out_last)
    );

    assign s_tready = cmd.in_ready;
    assign m_tvalid = out_valid;
    assign m_tuser  = out_kind;
    assign m_tlast  = out_last;

    // pack result fields, first field in the low bits
    assign m_tdata = {
        (OUT_DATA_W - FIELDS_W)'(0),
        out_err,
        out_tc,
        out_txt,
        out_flt,
        out_int,
        out_idx,
        out_id
    };

endmodule

`default_nettype wire

// File: sv/sfd_checker.sv
// ----------------------------------------------------------------------------
// sfd_checker
// port level checks of the frame decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [sfd_pkg::OUT_DATA_W-1:0]  m_tdata,
    input wire [2:0]                      m_tuser,
    input wire                            m_tlast
);
    import sfd_pkg::*;

    logic [2:0] err_field;
    assign err_field = m_tdata[ERR_LSB +: 3];

    // a waiting result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no bytes are taken while a result is pending
    a_no_intake: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(s_tready && s_tvalid))
        else $error("byte taken during decode");

    // an error ends the frame
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_ERR |-> m_tlast)
        else $error("error item not last");

    // error code set exactly on error items
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == KIND_ERR) == (err_field != ERR_NONE)))
        else $error("error code mismatch");

endmodule

bind serial_frame_decoder sfd_checker u_sfd_checker (.*);

`default_nettype wire
